[design/five_point_stencil_stream_assert.svh]
// Assertion macros for the five-point stencil stream.
`ifndef FIVE_POINT_STENCIL_STREAM_ASSERT_SVH
`define FIVE_POINT_STENCIL_STREAM_ASSERT_SVH

`ifndef SYNTHESIS
`define FPSS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
`define FPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define FPSS_ASSERT(label, clk, rst_n, prop)
`define FPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/fpss_pkg.sv]
package fpss_pkg;

  localparam int MAX_COLS_DEF    = 1024;
  localparam int MAX_ROWS_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF = 32;

  // configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 2'd1;
  localparam logic [CFG_W-1:0]     CFG_RESET    = 11'd1024;

  // Q0.16 weights: 0.6 and 0.1 rounded to nearest
  localparam int FRAC_BITS = 16;
  localparam logic [15:0] W_CENTRE   = 16'd39322;
  localparam logic [12:0] W_SIDE     = 13'd6554;
  localparam logic [16:0] ROUND_HALF = 17'd32768;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } fpss_flags_t;

endpackage

[design/five_point_stencil_stream.sv]
// Channel  Direction  Payload
// in_      slave      tdata: sample; tuser: opcode (0 sample, 1 drain)
// out_     master     tdata: filtered; tlast: row_end; tuser: frame_end
// cfg_     slave      cfg_index: register (0 grid_cols, 1 grid_rows); cfg_data: value
//
// One item per cycle while the output is not stalled. A result passes through
// the row store read, operand sum, two multipliers, then round and saturate
// into the output register.
// Reset is synchronous; row stores are not cleared. A write to grid_cols
// or grid_rows restarts the frame. Output stalls back up stage by stage;
// in_tready drops only once the row store stage holds an item it cannot pass on.
`include "five_point_stencil_stream_assert.svh"

module five_point_stencil_stream import fpss_pkg::*; #(
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DATA_W-1:0]    in_tdata,   // sample
  input  logic                 in_tuser,   // opcode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_W-1:0]    out_tdata,  // filtered
  output logic                 out_tlast,  // row_end
  output logic                 out_tuser,  // frame_end
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W = $clog2(MAX_ROWS + 1);

  function automatic int eff_limit(logic [CFG_W-1:0] v, int maxv);
    int r;
    r = int'(v);
    if (r == 0) r = 1;
    else if (r > maxv) r = maxv;
    return r;
  endfunction

  // configuration and counters
  logic [COL_W-1:0] cols_m1_r;
  logic [ROW_W-1:0] rows_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [SAMPLE_BITS-1:0] win1_r;

  // row store stage
  logic                   s1_valid_r, s1_emit_r, s1_we_r, s1_czero_r;
  logic                   s1_upper_r, s1_last_r;
  fpss_flags_t            s1_flags_r;
  logic [COL_W-1:0]       s1_addr_r;
  logic [SAMPLE_BITS-1:0] s1_lower_r;
  logic                   fwd0_r, fwd1_r;
  logic [SAMPLE_BITS-1:0] fwd_lower_r, fwd_upper_r;

  logic                   cfg_wr, accept, drain, ignore, take, last_col;
  logic [COL_W-1:0]       col_next_addr;
  logic                   s1_ready, s1_leave;
  logic [SAMPLE_BITS-1:0] rd_centre0, rd_centre1, rd_upper;
  logic [SAMPLE_BITS-1:0] centre_eff, right_eff, upper_eff, left_eff;
  logic [SAMPLE_BITS+1:0] side_sum;
  logic                   w_in_ready, w_out_valid;
  logic [SAMPLE_BITS-1:0] w_result;
  fpss_flags_t            w_flags;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign s1_ready  = !s1_emit_r || w_in_ready;
  assign s1_leave  = s1_valid_r && s1_ready;
  assign in_tready = !s1_valid_r || s1_ready;
  assign accept    = in_tvalid && in_tready;

  assign drain    = in_tuser;
  assign ignore   = drain ? (row_r < rows_r) : (row_r >= rows_r);
  assign take     = accept && !ignore;
  assign last_col = (col_r == cols_m1_r);
  assign col_next_addr = col_r + COL_W'(1);

  always_comb begin
    centre_eff = fwd0_r ? fwd_lower_r : rd_centre0;
    right_eff  = s1_last_r ? '0 : (fwd1_r ? fwd_lower_r : rd_centre1);
    upper_eff  = s1_upper_r ? (fwd0_r ? fwd_upper_r : rd_upper) : '0;
    left_eff   = s1_czero_r ? '0 : win1_r;
    side_sum   = (SAMPLE_BITS+2)'(upper_eff) + (SAMPLE_BITS+2)'(s1_lower_r)
               + (SAMPLE_BITS+2)'(left_eff) + (SAMPLE_BITS+2)'(right_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_m1_r  <= COL_W'(eff_limit(CFG_RESET, MAX_COLS) - 1);
      rows_r     <= ROW_W'(eff_limit(CFG_RESET, MAX_ROWS));
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      fwd0_r     <= 1'b0;
      fwd1_r     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_IDX_COLS: begin
            cols_m1_r <= COL_W'(eff_limit(cfg_data, MAX_COLS) - 1);
            col_r     <= '0;
            row_r     <= '0;
          end
          CFG_IDX_ROWS: begin
            rows_r <= ROW_W'(eff_limit(cfg_data, MAX_ROWS));
            col_r  <= '0;
            row_r  <= '0;
          end
          default: ;
        endcase
      end else if (take) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= drain ? '0 : row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
      if (take) begin
        s1_valid_r <= 1'b1;
        // the item leaving now writes the entry this one reads
        fwd0_r <= s1_leave && s1_we_r && (s1_addr_r == col_r);
        fwd1_r <= s1_leave && s1_we_r && (s1_addr_r == col_next_addr);
      end else if (s1_leave) begin
        s1_valid_r <= 1'b0;
        fwd0_r     <= 1'b0;
        fwd1_r     <= 1'b0;
      end
    end
    if (take) begin
      s1_emit_r            <= (row_r != '0);
      s1_upper_r           <= (row_r > ROW_W'(1));
      s1_we_r              <= !drain;
      s1_czero_r           <= (col_r == '0);
      s1_last_r            <= last_col;
      s1_flags_r.row_end   <= last_col;
      s1_flags_r.frame_end <= drain && last_col;
      s1_addr_r            <= col_r;
      s1_lower_r           <= drain ? '0 : in_tdata[SAMPLE_BITS-1:0];
      fwd_lower_r          <= s1_lower_r;
      fwd_upper_r          <= centre_eff;
    end
    if (s1_leave) begin
      win1_r <= centre_eff;
    end
  end

  fpss_row_store #(
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COL_W       (COL_W)
  ) u_store (
    .clk        (clk),
    .rd_en      (take),
    .rd_addr0   (col_r),
    .rd_addr1   (col_next_addr),
    .rd_centre0 (rd_centre0),
    .rd_centre1 (rd_centre1),
    .rd_upper   (rd_upper),
    .wr_en      (s1_leave && s1_we_r),
    .wr_addr    (s1_addr_r),
    .wr_centre  (s1_lower_r),
    .wr_upper   (centre_eff)
  );

  fpss_weigh #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_weigh (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r && s1_emit_r),
    .in_ready  (w_in_ready),
    .centre    (centre_eff),
    .side_sum  (side_sum),
    .in_flags  (s1_flags_r),
    .out_valid (w_out_valid),
    .out_ready (out_tready),
    .result    (w_result),
    .out_flags (w_flags)
  );

  assign out_tvalid = w_out_valid;
  assign out_tdata  = DATA_W'(w_result);
  assign out_tlast  = w_flags.row_end;
  assign out_tuser  = w_flags.frame_end;

  `FPSS_ASSERT(a_col_in_range, clk, rst_n, col_r <= cols_m1_r)
  `FPSS_ASSERT(a_row_in_range, clk, rst_n, row_r <= rows_r)
  `FPSS_ASSERT(a_no_take_when_blocked, clk, rst_n, !(s1_valid_r && !s1_ready && take))
  `FPSS_ASSERT(a_fwd_needs_item, clk, rst_n, !(fwd0_r || fwd1_r) || s1_valid_r)
  `FPSS_ASSERT_NEXT(a_frame_end_restarts, clk, rst_n,
    take && drain && last_col && !cfg_wr, row_r == '0 && col_r == '0)

endmodule

[design/fpss_row_store.sv]
module fpss_row_store import fpss_pkg::*; #(
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [COL_W-1:0]       rd_addr0,
  input  logic [COL_W-1:0]       rd_addr1,
  output logic [SAMPLE_BITS-1:0] rd_centre0,
  output logic [SAMPLE_BITS-1:0] rd_centre1,
  output logic [SAMPLE_BITS-1:0] rd_upper,
  input  logic                   wr_en,
  input  logic [COL_W-1:0]       wr_addr,
  input  logic [SAMPLE_BITS-1:0] wr_centre,
  input  logic [SAMPLE_BITS-1:0] wr_upper
);

  logic [SAMPLE_BITS-1:0] centre_mem [MAX_COLS];
  logic [SAMPLE_BITS-1:0] upper_mem  [MAX_COLS];

  // read-before-write on a shared address; the caller forwards
  always_ff @(posedge clk) begin
    if (wr_en) begin
      centre_mem[wr_addr] <= wr_centre;
      upper_mem[wr_addr]  <= wr_upper;
    end
    if (rd_en) begin
      rd_centre0 <= centre_mem[rd_addr0];
      rd_centre1 <= centre_mem[rd_addr1];
      rd_upper   <= upper_mem[rd_addr0];
    end
  end

endmodule

[design/fpss_weigh.sv]
module fpss_weigh import fpss_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] centre,
  input  logic [SAMPLE_BITS+1:0] side_sum,
  input  fpss_flags_t            in_flags,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] result,
  output fpss_flags_t            out_flags
);

  localparam int PC_W  = SAMPLE_BITS + 16;
  localparam int PS_W  = SAMPLE_BITS + 15;
  localparam int TOT_W = SAMPLE_BITS + 17;

  logic                   s2_valid_r, s3_valid_r, out_valid_r;
  logic [SAMPLE_BITS-1:0] s2_centre_r;
  logic [SAMPLE_BITS+1:0] s2_side_r;
  fpss_flags_t            s2_flags_r, s3_flags_r, out_flags_r;
  logic [PC_W-1:0]        s3_prod_c_r;
  logic [PS_W-1:0]        s3_prod_s_r;
  logic [SAMPLE_BITS-1:0] result_r;

  logic                   s2_ready, s3_ready;
  logic [TOT_W-1:0]       total;
  logic [SAMPLE_BITS:0]   scaled;
  logic [SAMPLE_BITS-1:0] result_nxt;

  assign s3_ready = !out_valid_r || out_ready;
  assign s2_ready = !s3_valid_r || s3_ready;
  assign in_ready = !s2_valid_r || s2_ready;

  always_comb begin
    total  = TOT_W'(s3_prod_c_r) + TOT_W'(s3_prod_s_r) + TOT_W'(ROUND_HALF);
    scaled = total[TOT_W-1:FRAC_BITS];
    result_nxt = scaled[SAMPLE_BITS] ? '1 : scaled[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s2_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s3_valid_r <= s2_valid_r;
      end
      if (s3_ready) begin
        out_valid_r <= s3_valid_r;
      end
    end
    if (in_ready) begin
      s2_centre_r <= centre;
      s2_side_r   <= side_sum;
      s2_flags_r  <= in_flags;
    end
    if (s2_ready) begin
      s3_prod_c_r <= PC_W'(s2_centre_r) * PC_W'(W_CENTRE);
      s3_prod_s_r <= PS_W'(s2_side_r) * PS_W'(W_SIDE);
      s3_flags_r  <= s2_flags_r;
    end
    if (s3_ready) begin
      result_r    <= result_nxt;
      out_flags_r <= s3_flags_r;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;
  assign out_flags = out_flags_r;

endmodule
